/* rtl/crank_nicolson_wave_step_macros.svh */
// Assertion macros used by the wave step controller.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef CRANK_NICOLSON_WAVE_STEP_MACROS_SVH
`define CRANK_NICOLSON_WAVE_STEP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CNWS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CNWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cnws_pkg.sv */
// Shared constants, types and helper functions of the wave step block.
// No dependencies; every RTL module imports this package.
package cnws_pkg;

	localparam int POINTS    = 1024;
	localparam int FRAC_BITS = 28;
	localparam int IDX_W     = $clog2(POINTS);
	localparam int DATA_W    = 32;
	localparam int SIDX_W    = 10;
	localparam int BAR_W     = 10;
	localparam int CMP_W     = (IDX_W > BAR_W) ? IDX_W + 1 : BAR_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int FS_W      = PROD_W - FRAC_BITS;
	localparam int ACC_W     = FS_W + 2;
	localparam int SAT_W     = ACC_W;
	localparam int DIV_STEPS = 2 * FRAC_BITS + DATA_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
	localparam int QUO_W     = DATA_W + 1;
	localparam int CM_LAST   = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_DIAG_RE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIAG_IM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RHS_RE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RHS_IM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR_H   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR_LO  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR_HI  = 3'd6;

	localparam logic signed [DATA_W-1:0] DIAG_RE_RST = DATA_W'(-(64'sd2 <<< FRAC_BITS));
	localparam logic [BAR_W-1:0] BAR_LO_RST = 10'd410;
	localparam logic [BAR_W-1:0] BAR_HI_RST = 10'd614;

	localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_STEP  = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
	} cval_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_WRITE, OP_READ, OP_OUT, OP_STEP_INIT,
		OP_A_LOAD, OP_SQ0, OP_SQ1, OP_SQ2, OP_DIV, OP_A_WR,
		OP_B_RD, OP_B_LD, OP_B_SUB, OP_B_WR,
		OP_C_RD, OP_C_LD, OP_C_WR,
		OP_CM0, OP_CM1, OP_CM2, OP_CM3, OP_CM4,
		OP_ZERO
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [IDX_W-1:0] idx;
		logic             zero;
	} dp_cmd_t;

	typedef struct packed {
		logic div_idle;
	} dp_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD, ST_RD_OUT,
		ST_A_LOAD, ST_A_SQ0, ST_A_SQ1, ST_A_SQ2, ST_A_DIV, ST_A_WAIT, ST_A_WR,
		ST_B_RD, ST_B_LD, ST_B_CM1, ST_B_SUB, ST_B_CM2, ST_B_WR,
		ST_C_RD, ST_C_LD, ST_C_CM, ST_C_WR,
		ST_Z0, ST_Z1
	} ctrl_state_t;

	// Clamp a wide signed value to the 32-bit signed range.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-DATA_W:0] top;
		top = v[SAT_W-1:DATA_W-1];
		if ((top == '0) || (top == '1)) begin
			return v[DATA_W-1:0];
		end
		return v[SAT_W-1] ? S32_MIN : S32_MAX;
	endfunction

endpackage

/* rtl/crank_nicolson_wave_step.sv */
// Crank-Nicolson wave step. A write beat is taken while idle; a read beat passes
// through the read and output states and shows its result, later while the output
// beat before it is not taken. A step beat runs the coefficient sweep, with a
// one-bit-a-cycle reciprocal divide per coefficient, then the back and forward
// sweeps. One beat is worked on at a time. The asynchronous reset restores the
// configuration defaults; the sample memories stay undefined.
module crank_nicolson_wave_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     kind,
	input  logic [cnws_pkg::SIDX_W-1:0]    sample_index,
	input  logic signed [cnws_pkg::DATA_W-1:0] in_re,
	input  logic signed [cnws_pkg::DATA_W-1:0] in_im,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [cnws_pkg::DATA_W-1:0] out_re,
	output logic signed [cnws_pkg::DATA_W-1:0] out_im,
	input  logic                           cfg_we,
	input  logic [cnws_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cnws_pkg::DATA_W-1:0]    cfg_data
);
	import cnws_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	cnws_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.sample_index (sample_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	cnws_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_re    (in_re),
		.in_im    (in_im),
		.out_re   (out_re),
		.out_im   (out_im)
	);

endmodule

/* rtl/cnws_div.sv */
// Radix-2 restoring divider: floor(mag * 2^(2*FRAC_BITS) / den), one bit a cycle.
// Depends on cnws_pkg; the quotient saturates to all ones when it overflows.
module cnws_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cnws_pkg::DATA_W-1:0] mag,
	input  logic [cnws_pkg::PROD_W-1:0] den,
	output logic                        busy,
	output logic [cnws_pkg::QUO_W-1:0]  quo
);
	import cnws_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    num_q;
	logic [PROD_W:0]      rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 ovf_q;
	logic [PROD_W:0]      trial;
	logic                 fits;

	assign trial = {rem_q[PROD_W-1:0], num_q[DATA_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= mag;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[DATA_W-2:0], 1'b0};
			rem_q <= fits ? trial - {1'b0, den} : trial;
			// A bit falling off the top means the quotient is far out of range.
			ovf_q <= ovf_q | quo_q[QUO_W-1];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = ovf_q ? '1 : quo_q;

endmodule

/* rtl/cnws_dp.sv */
// Datapath of the wave step: sample and coefficient memories, configuration
// registers, one shared multiplier and two dividers. Depends on cnws_pkg, cnws_div.
module cnws_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cnws_pkg::dp_cmd_t              cmd,
	output cnws_pkg::dp_sts_t              sts,
	input  logic                           cfg_we,
	input  logic [cnws_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cnws_pkg::DATA_W-1:0]    cfg_data,
	input  logic signed [cnws_pkg::DATA_W-1:0] in_re,
	input  logic signed [cnws_pkg::DATA_W-1:0] in_im,
	output logic signed [cnws_pkg::DATA_W-1:0] out_re,
	output logic signed [cnws_pkg::DATA_W-1:0] out_im
);
	import cnws_pkg::*;

	logic signed [DATA_W-1:0] diag_re_q, diag_im_q, rhs_re_q, rhs_im_q, bar_h_q;
	logic [BAR_W-1:0]         bar_lo_q, bar_hi_q;

	cval_t wave_mem  [POINTS];
	cval_t alpha_mem [POINTS-1];
	cval_t gamma_mem [POINTS-1];
	cval_t beta_mem  [POINTS-1];

	cval_t wave_rd_q, alpha_rd_q, gamma_rd_q, beta_rd_q;
	cval_t x_q, y_q, a_q, b_q, c_q, out_q;
	logic [PROD_W-1:0]        d_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;

	logic [IDX_W-1:0]         idx_p1, idx_m1, wave_raddr;
	logic                     wave_rd_en, wave_we, in_bar;
	cval_t                    wave_wdata, den, cm, u_val, chi, wave_new, gamma_new, alpha_new;
	logic signed [DATA_W-1:0] den_re1, mul_a, mul_b;
	logic signed [FS_W-1:0]   fs_prod;
	logic [DATA_W-1:0]        mag_re, mag_im;
	logic [QUO_W-1:0]         quo_re, quo_im;
	logic                     busy_re, busy_im, div_start;

	// Apply the sign to a saturated magnitude quotient and clamp to 32 bits.
	function automatic logic signed [DATA_W-1:0] sign_sat(input logic [QUO_W-1:0] q,
			input logic neg);
		logic [QUO_W-1:0] lim;
		lim = {1'b0, S32_MIN};
		if (neg) begin
			return (q > lim) ? S32_MIN : DATA_W'(-q);
		end
		return (q >= lim) ? S32_MAX : q[DATA_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diag_re_q <= DIAG_RE_RST;
			diag_im_q <= '0;
			rhs_re_q  <= '0;
			rhs_im_q  <= '0;
			bar_h_q   <= '0;
			bar_lo_q  <= BAR_LO_RST;
			bar_hi_q  <= BAR_HI_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DIAG_RE: diag_re_q <= cfg_data;
				CFG_DIAG_IM: diag_im_q <= cfg_data;
				CFG_RHS_RE:  rhs_re_q  <= cfg_data;
				CFG_RHS_IM:  rhs_im_q  <= cfg_data;
				CFG_BAR_H:   bar_h_q   <= cfg_data;
				CFG_BAR_LO:  bar_lo_q  <= cfg_data[BAR_W-1:0];
				CFG_BAR_HI:  bar_hi_q  <= cfg_data[BAR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign idx_p1 = cmd.idx + 1'b1;
	assign idx_m1 = cmd.idx - 1'b1;

	// Denominator of the coefficient sweep: diag - V[j+1] + alpha[j+1].
	assign in_bar  = (CMP_W'(idx_p1) >= CMP_W'(bar_lo_q)) && (CMP_W'(idx_p1) <= CMP_W'(bar_hi_q));
	assign den_re1 = sat32(SAT_W'(diag_re_q) - (in_bar ? SAT_W'(bar_h_q) : SAT_W'(0)));
	assign den.re  = sat32(SAT_W'(den_re1) + SAT_W'(a_q.re));
	assign den.im  = sat32(SAT_W'(diag_im_q) + SAT_W'(a_q.im));

	assign cm.re    = sat32(acc_re_q);
	assign cm.im    = sat32(acc_im_q);
	assign u_val.re = sat32(SAT_W'(cm.re) - SAT_W'(b_q.re));
	assign u_val.im = sat32(SAT_W'(cm.im) - SAT_W'(b_q.im));
	assign chi.re   = sat32(SAT_W'(cm.re) + SAT_W'(beta_rd_q.re));
	assign chi.im   = sat32(SAT_W'(cm.im) + SAT_W'(beta_rd_q.im));
	assign wave_new.re = sat32(SAT_W'(chi.re) - SAT_W'(wave_rd_q.re));
	assign wave_new.im = sat32(SAT_W'(chi.im) - SAT_W'(wave_rd_q.im));

	// Reciprocal of x_q: (re - i im) / |x|^2, with a zero divisor giving (max, 0).
	assign mag_re = x_q.re[DATA_W-1] ? DATA_W'(-x_q.re) : x_q.re;
	assign mag_im = x_q.im[DATA_W-1] ? DATA_W'(-x_q.im) : x_q.im;
	always_comb begin
		if (d_q == '0) begin
			gamma_new.re = S32_MAX;
			gamma_new.im = '0;
		end else begin
			gamma_new.re = sign_sat(quo_re, x_q.re[DATA_W-1]);
			gamma_new.im = sign_sat(quo_im, !x_q.im[DATA_W-1] && (x_q.im != '0));
		end
	end
	assign alpha_new.re = sat32(-SAT_W'(gamma_new.re));
	assign alpha_new.im = sat32(-SAT_W'(gamma_new.im));

	assign div_start = cmd.op == OP_DIV;

	cnws_div u_div_re (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (mag_re),
		.den    (d_q),
		.busy   (busy_re),
		.quo    (quo_re)
	);

	cnws_div u_div_im (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (mag_im),
		.den    (d_q),
		.busy   (busy_im),
		.quo    (quo_im)
	);

	assign sts.div_idle = !busy_re && !busy_im;

	always_comb begin
		case (cmd.op)
			OP_SQ0: begin mul_a = x_q.re; mul_b = x_q.re; end
			OP_SQ1: begin mul_a = x_q.im; mul_b = x_q.im; end
			OP_CM1: begin mul_a = x_q.im; mul_b = y_q.im; end
			OP_CM2: begin mul_a = x_q.re; mul_b = y_q.im; end
			OP_CM3: begin mul_a = x_q.im; mul_b = y_q.re; end
			default: begin mul_a = x_q.re; mul_b = y_q.re; end
		endcase
	end

	assign fs_prod = FS_W'(prod_s1 >>> FRAC_BITS);

	// Each multiply op after the first of a run retires the product issued in the cycle before.
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		case (cmd.op)
			OP_STEP_INIT: begin
				a_q <= '0;
				b_q <= '0;
				c_q <= '0;
			end
			OP_A_LOAD: x_q <= den;
			OP_SQ1:    d_q <= prod_s1;
			OP_SQ2:    d_q <= d_q + prod_s1;
			OP_A_WR:   a_q <= alpha_new;
			OP_B_LD: begin
				x_q <= {rhs_re_q, rhs_im_q};
				y_q <= wave_rd_q;
			end
			OP_B_SUB: begin
				x_q <= gamma_rd_q;
				y_q <= u_val;
			end
			OP_B_WR: b_q <= cm;
			OP_C_LD: begin
				x_q <= alpha_rd_q;
				y_q <= c_q;
			end
			OP_C_WR: c_q <= chi;
			OP_CM1:  acc_re_q <= ACC_W'(fs_prod);
			OP_CM2:  acc_re_q <= acc_re_q - ACC_W'(fs_prod);
			OP_CM3:  acc_im_q <= ACC_W'(fs_prod);
			OP_CM4:  acc_im_q <= acc_im_q + ACC_W'(fs_prod);
			OP_OUT:  out_q <= cmd.zero ? '0 : wave_rd_q;
			default: begin
			end
		endcase
	end

	assign wave_rd_en = (cmd.op == OP_READ) || (cmd.op == OP_B_RD) || (cmd.op == OP_C_RD);
	assign wave_raddr = (cmd.op == OP_B_RD) ? idx_p1 : cmd.idx;
	assign wave_we    = (cmd.op == OP_WRITE) || (cmd.op == OP_C_WR) || (cmd.op == OP_ZERO);

	always_comb begin
		case (cmd.op)
			OP_WRITE: wave_wdata = {in_re, in_im};
			OP_C_WR:  wave_wdata = wave_new;
			default:  wave_wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wave_rd_en) begin
			wave_rd_q <= wave_mem[wave_raddr];
		end
		if (wave_we) begin
			wave_mem[cmd.idx] <= wave_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_B_RD) begin
			gamma_rd_q <= gamma_mem[idx_p1];
		end
		if (cmd.op == OP_A_WR) begin
			gamma_mem[idx_p1] <= gamma_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_C_RD) begin
			alpha_rd_q <= alpha_mem[idx_m1];
		end
		if (cmd.op == OP_A_WR) begin
			alpha_mem[cmd.idx] <= alpha_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_C_RD) begin
			beta_rd_q <= beta_mem[idx_m1];
		end
		if (cmd.op == OP_B_WR) begin
			beta_mem[cmd.idx] <= cm;
		end
	end

	assign out_re = out_q.re;
	assign out_im = out_q.im;

endmodule

/* rtl/cnws_ctrl.sv */
// Controller of the wave step: input and output handshakes and the sweep sequencer.
// Depends on cnws_pkg and the assertion macros header.
module cnws_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  kind,
	input  logic [cnws_pkg::SIDX_W-1:0] sample_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cnws_pkg::dp_cmd_t           cmd,
	input  cnws_pkg::dp_sts_t           sts
);
	import cnws_pkg::*;

	ctrl_state_t      state_q, state_d;
	logic [IDX_W-1:0] j_q, ridx_q;
	logic [2:0]       cm_q;
	logic             rzero_q, out_valid_q;
	logic             accept, in_range, out_free, cm_done;

	localparam logic [IDX_W-1:0] J_TOP  = IDX_W'(POINTS - 3);
	localparam logic [IDX_W-1:0] J_LAST = IDX_W'(POINTS - 2);

	function automatic dp_op_t cm_op(input logic [2:0] step);
		case (step)
			3'd0:    return OP_CM0;
			3'd1:    return OP_CM1;
			3'd2:    return OP_CM2;
			3'd3:    return OP_CM3;
			default: return OP_CM4;
		endcase
	endfunction

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign in_range = 32'(sample_index) < POINTS;
	assign out_free = !out_valid_q || out_ready;
	assign cm_done  = cm_q == 3'(CM_LAST);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (kind == KIND_STEP)) begin
					state_d = ST_A_LOAD;
				end else if (accept && (kind == KIND_READ)) begin
					state_d = ST_RD;
				end
			end
			ST_RD:     state_d = ST_RD_OUT;
			ST_RD_OUT: if (out_free) state_d = ST_IDLE;
			ST_A_LOAD: state_d = ST_A_SQ0;
			ST_A_SQ0:  state_d = ST_A_SQ1;
			ST_A_SQ1:  state_d = ST_A_SQ2;
			ST_A_SQ2:  state_d = ST_A_DIV;
			ST_A_DIV:  state_d = ST_A_WAIT;
			ST_A_WAIT: if (sts.div_idle) state_d = ST_A_WR;
			ST_A_WR:   state_d = (j_q == '0) ? ST_B_RD : ST_A_LOAD;
			ST_B_RD:   state_d = ST_B_LD;
			ST_B_LD:   state_d = ST_B_CM1;
			ST_B_CM1:  if (cm_done) state_d = ST_B_SUB;
			ST_B_SUB:  state_d = ST_B_CM2;
			ST_B_CM2:  if (cm_done) state_d = ST_B_WR;
			ST_B_WR:   state_d = (j_q == '0) ? ST_C_RD : ST_B_RD;
			ST_C_RD:   state_d = ST_C_LD;
			ST_C_LD:   state_d = ST_C_CM;
			ST_C_CM:   if (cm_done) state_d = ST_C_WR;
			ST_C_WR:   state_d = (j_q == J_LAST) ? ST_Z0 : ST_C_RD;
			ST_Z0:     state_d = ST_Z1;
			ST_Z1:     state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NOP;
		cmd.idx  = j_q;
		cmd.zero = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.idx = IDX_W'(sample_index);
				if (accept && (kind == KIND_WRITE) && in_range) begin
					cmd.op = OP_WRITE;
				end else if (accept && (kind == KIND_STEP)) begin
					cmd.op = OP_STEP_INIT;
				end
			end
			ST_RD: begin
				cmd.op  = OP_READ;
				cmd.idx = ridx_q;
			end
			ST_RD_OUT: begin
				cmd.op   = out_free ? OP_OUT : OP_NOP;
				cmd.zero = rzero_q;
			end
			ST_A_LOAD: cmd.op = OP_A_LOAD;
			ST_A_SQ0:  cmd.op = OP_SQ0;
			ST_A_SQ1:  cmd.op = OP_SQ1;
			ST_A_SQ2:  cmd.op = OP_SQ2;
			ST_A_DIV:  cmd.op = OP_DIV;
			ST_A_WR:   cmd.op = OP_A_WR;
			ST_B_RD:   cmd.op = OP_B_RD;
			ST_B_LD:   cmd.op = OP_B_LD;
			ST_B_CM1:  cmd.op = cm_op(cm_q);
			ST_B_SUB:  cmd.op = OP_B_SUB;
			ST_B_CM2:  cmd.op = cm_op(cm_q);
			ST_B_WR:   cmd.op = OP_B_WR;
			ST_C_RD:   cmd.op = OP_C_RD;
			ST_C_LD:   cmd.op = OP_C_LD;
			ST_C_CM:   cmd.op = cm_op(cm_q);
			ST_C_WR:   cmd.op = OP_C_WR;
			ST_Z0: begin
				cmd.op  = OP_ZERO;
				cmd.idx = '0;
			end
			ST_Z1: begin
				cmd.op  = OP_ZERO;
				cmd.idx = IDX_W'(POINTS - 1);
			end
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			j_q         <= '0;
			cm_q        <= '0;
			ridx_q      <= '0;
			rzero_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_B_CM1) || (state_q == ST_B_CM2) || (state_q == ST_C_CM)) begin
				cm_q <= cm_done ? '0 : cm_q + 1'b1;
			end else begin
				cm_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (kind == KIND_STEP)) begin
						j_q <= J_TOP;
					end
					if (accept && (kind == KIND_READ)) begin
						ridx_q  <= IDX_W'(sample_index);
						rzero_q <= !in_range;
					end
				end
				ST_A_WR: j_q <= (j_q == '0) ? J_TOP : j_q - 1'b1;
				ST_B_WR: j_q <= (j_q == '0) ? IDX_W'(1) : j_q - 1'b1;
				ST_C_WR: j_q <= j_q + 1'b1;
				default: begin
				end
			endcase
			if ((state_q == ST_RD_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`include "crank_nicolson_wave_step_macros.svh"

	`CNWS_ASSERT_NEXT(a_div_starts, state_q == ST_A_DIV, !sts.div_idle, "divider did not start")
	`CNWS_ASSERT_SAME(a_div_done, state_q == ST_A_WR, sts.div_idle, "coefficient written mid-divide")
	`CNWS_ASSERT_NEXT(a_read_shown, (state_q == ST_RD_OUT) && out_free,
		out_valid_q && (state_q == ST_IDLE), "read beat not presented")
	`CNWS_ASSERT_SAME(a_chi_range, state_q == ST_C_WR, j_q != '0, "forward sweep hit an end sample")

endmodule

/* tb/sv/tb.sv */
// Testbench for crank_nicolson_wave_step: random and directed sample writes, reads and steps.
// Needs cnws_pkg and the RTL top level; a built-in predictor checks every read result.
`timescale 1ns / 100ps

module tb;
	import cnws_pkg::*;

	localparam int NPTS = POINTS;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
	localparam int WATCHDOG_LIMIT = 500000;

	typedef struct {
		logic [1:0]               k;
		logic [SIDX_W-1:0]        idx;
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
	} wave_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = '0;
	logic [SIDX_W-1:0] sample_index = '0;
	logic signed [DATA_W-1:0] in_re = '0;
	logic signed [DATA_W-1:0] in_im = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DATA_W-1:0] out_re;
	logic signed [DATA_W-1:0] out_im;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	crank_nicolson_wave_step dut (.*);

	always #2 clk = ~clk;

	wave_op_t pending_ops[$];
	cval_t    expected_samples[$];
	int       mismatches = 0;
	int       in_gap = 0;
	int       out_hold = 0;
	int       idle_cycles = 0;
	logic     in_took = 1'b0;
	logic     rst_done = 1'b0;
	logic     burst = 1'b0;
	wave_op_t cur_op;

	// Predictor state.
	cval_t wave_m[NPTS];
	cval_t alpha_m[NPTS];
	cval_t gamma_m[NPTS];
	cval_t beta_m[NPTS];
	cval_t chi_m[NPTS];
	logic signed [DATA_W-1:0] m_diag_re, m_diag_im, m_rhs_re, m_rhs_im, m_bar_h;
	logic [BAR_W-1:0] m_bar_lo, m_bar_hi;

	function automatic logic signed [DATA_W-1:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[DATA_W-1:0];
	endfunction

	function automatic cval_t c_add(cval_t a, cval_t b);
		cval_t r;
		r.re = clamp32(longint'($signed(a.re)) + longint'($signed(b.re)));
		r.im = clamp32(longint'($signed(a.im)) + longint'($signed(b.im)));
		return r;
	endfunction

	function automatic cval_t c_sub(cval_t a, cval_t b);
		cval_t r;
		r.re = clamp32(longint'($signed(a.re)) - longint'($signed(b.re)));
		r.im = clamp32(longint'($signed(a.im)) - longint'($signed(b.im)));
		return r;
	endfunction

	// Partial products are floored before they are combined.
	function automatic longint prod_floor(logic signed [DATA_W-1:0] a,
			logic signed [DATA_W-1:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> FRAC_BITS;
	endfunction

	function automatic cval_t c_mul(cval_t a, cval_t b);
		cval_t r;
		r.re = clamp32(prod_floor(a.re, b.re) - prod_floor(a.im, b.im));
		r.im = clamp32(prod_floor(a.re, b.im) + prod_floor(a.im, b.re));
		return r;
	endfunction

	function automatic longint unsigned long_quot(longint unsigned mag, longint unsigned d);
		longint unsigned r, q, b;
		r = 0;
		q = 0;
		for (int i = 2 * FRAC_BITS + 31; i >= 0; i--) begin
			b = (i >= 2 * FRAC_BITS) ? ((mag >> (i - 2 * FRAC_BITS)) & 64'd1) : 64'd0;
			r = (r << 1) | b;
			if (q > (64'd1 << 33)) q = 64'd1 << 33;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		if (q > (64'd1 << 33)) q = 64'd1 << 33;
		return q;
	endfunction

	function automatic logic signed [DATA_W-1:0] recip_part(longint num, longint unsigned d);
		longint unsigned mag;
		longint q;
		mag = (num >= 0) ? longint'(num) : longint'(-num);
		q = longint'(long_quot(mag, d));
		return clamp32(num >= 0 ? q : -q);
	endfunction

	function automatic cval_t c_recip(cval_t x);
		cval_t r;
		longint unsigned d;
		d = longint'(longint'($signed(x.re)) * longint'($signed(x.re)))
			+ longint'(longint'($signed(x.im)) * longint'($signed(x.im)));
		if (d == 0) begin
			r.re = S32_MAX;
			r.im = '0;
			return r;
		end
		r.re = recip_part(longint'($signed(x.re)), d);
		r.im = recip_part(-longint'($signed(x.im)), d);
		return r;
	endfunction

	task automatic advance_wave();
		cval_t zero, den, diag, rhs;
		int p;
		zero = '0;
		diag.re = m_diag_re;
		diag.im = m_diag_im;
		rhs.re = m_rhs_re;
		rhs.im = m_rhs_im;
		alpha_m[NPTS-2] = zero;
		for (int j = NPTS - 3; j >= 0; j--) begin
			p = j + 1;
			den = diag;
			if (p >= m_bar_lo && p <= m_bar_hi)
				den.re = clamp32(longint'($signed(den.re)) - longint'(m_bar_h));
			den = c_add(den, alpha_m[j+1]);
			gamma_m[j+1] = c_recip(den);
			alpha_m[j] = c_sub(zero, gamma_m[j+1]);
		end
		beta_m[NPTS-2] = zero;
		for (int j = NPTS - 3; j >= 0; j--)
			beta_m[j] = c_mul(gamma_m[j+1], c_sub(c_mul(rhs, wave_m[j+1]), beta_m[j+1]));
		chi_m[0] = zero;
		chi_m[NPTS-1] = zero;
		for (int j = 1; j < NPTS - 1; j++)
			chi_m[j] = c_add(c_mul(alpha_m[j-1], chi_m[j-1]), beta_m[j-1]);
		wave_m[0] = zero;
		wave_m[NPTS-1] = zero;
		for (int j = 1; j < NPTS - 1; j++)
			wave_m[j] = c_sub(chi_m[j], wave_m[j]);
	endtask

	task automatic predict_beat(wave_op_t op);
		cval_t v;
		case (op.k)
			KIND_WRITE: begin
				wave_m[op.idx].re = op.re;
				wave_m[op.idx].im = op.im;
			end
			KIND_STEP: advance_wave();
			KIND_READ: begin
				v = wave_m[op.idx];
				expected_samples.push_back(v);
			end
			default: ;
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		if (burst) return 0;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Driver: inputs change on the falling edge only.
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (rst_done && pending_ops.size() > 0) begin
				cur_op = pending_ops.pop_front();
				kind <= cur_op.k;
				sample_index <= cur_op.idx;
				in_re <= cur_op.re;
				in_im <= cur_op.im;
				in_valid <= 1'b1;
				in_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (out_hold > 0) begin
			out_hold <= out_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!burst && $urandom_range(9) == 0) out_hold <= pick_gap();
		end
	end

	// Monitor: sample at the rising edge, predict on input beats, check output beats.
	always @(posedge clk) begin
		wave_op_t op;
		cval_t want;
		in_took <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			op.k = kind;
			op.idx = sample_index;
			op.re = in_re;
			op.im = in_im;
			predict_beat(op);
		end
		if (out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat re=%h im=%h", out_re, out_im);
			end else begin
				want = expected_samples.pop_front();
				if (want.re !== out_re || want.im !== out_im) begin
					mismatches++;
					if (mismatches <= 10)
						$display("read mismatch: expected re=%h im=%h got re=%h im=%h",
							want.re, want.im, out_re, out_im);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic push_op(logic [1:0] k, int idx, logic [DATA_W-1:0] re, logic [DATA_W-1:0] im);
		wave_op_t op;
		op.k = k;
		op.idx = idx[SIDX_W-1:0];
		op.re = re;
		op.im = im;
		pending_ops.push_back(op);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		case (idx)
			CFG_DIAG_RE: m_diag_re = val;
			CFG_DIAG_IM: m_diag_im = val;
			CFG_RHS_RE:  m_rhs_re = val;
			CFG_RHS_IM:  m_rhs_im = val;
			CFG_BAR_H:   m_bar_h = val;
			CFG_BAR_LO:  m_bar_lo = val[BAR_W-1:0];
			CFG_BAR_HI:  m_bar_hi = val[BAR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Every phase ends with a read, so its result means the block is idle again.
	task automatic drain();
		push_op(KIND_READ, $urandom_range(NPTS - 1), $urandom, $urandom);
		while (pending_ops.size() > 0 || in_valid || expected_samples.size() > 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic step_and_probe();
		push_op(KIND_STEP, $urandom, $urandom, $urandom);
		push_op(KIND_READ, 0, 0, 0);
		push_op(KIND_READ, 1, 0, 0);
		push_op(KIND_READ, $urandom_range(NPTS - 2, 2), 0, 0);
		push_op(KIND_READ, NPTS - 1, 0, 0);
	endtask

	initial begin
		int r;
		m_diag_re = DIAG_RE_RST;
		m_diag_im = '0;
		m_rhs_re = '0;
		m_rhs_im = '0;
		m_bar_h = '0;
		m_bar_lo = BAR_LO_RST;
		m_bar_hi = BAR_HI_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		rst_done = 1'b1;

		// Every sample is written before any read or step; extremes go to a few spots.
		for (int i = 0; i < NPTS; i++) begin
			if (i == 0 || i == NPTS - 1)
				push_op(KIND_WRITE, i, S32_MAX, S32_MIN);
			else if (i == NPTS / 2)
				push_op(KIND_WRITE, i, S32_MIN, S32_MAX);
			else
				push_op(KIND_WRITE, i, $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
		end
		push_op(KIND_READ, 0, 0, 0);
		push_op(KIND_READ, NPTS - 1, 0, 0);
		push_op(KIND_READ, NPTS / 2, 0, 0);
		push_op(KIND_UNUSED, 5, 32'h1234_5678, 32'h9abc_def0);
		push_op(KIND_READ, 5, 0, 0);
		step_and_probe();
		drain();

		// Realistic terms with a random barrier.
		burst = 1'b1;
		write_reg(CFG_DIAG_RE, -(32'sd2 <<< FRAC_BITS));
		write_reg(CFG_DIAG_IM, 32'sd1 <<< (FRAC_BITS - 3));
		write_reg(CFG_RHS_RE, '0);
		write_reg(CFG_RHS_IM, 32'sd1 <<< (FRAC_BITS - 2));
		write_reg(CFG_BAR_H, $urandom_range(32'h1000_0000));
		write_reg(CFG_BAR_LO, ($urandom & 32'hffff_fc00) | 32'd300);
		write_reg(CFG_BAR_HI, 32'hffff_fc00 | 32'd700);
		write_reg(CFG_NONE, $urandom);
		step_and_probe();
		drain();

		// Extremes, with an empty barrier.
		burst = 1'b0;
		write_reg(CFG_DIAG_RE, S32_MIN);
		write_reg(CFG_DIAG_IM, S32_MAX);
		write_reg(CFG_RHS_RE, S32_MAX);
		write_reg(CFG_RHS_IM, S32_MIN);
		write_reg(CFG_BAR_H, S32_MIN);
		write_reg(CFG_BAR_LO, 32'd1023);
		write_reg(CFG_BAR_HI, 32'd0);
		step_and_probe();
		drain();

		// All-zero diagonal gives a zero divisor; the barrier covers every index.
		write_reg(CFG_DIAG_RE, '0);
		write_reg(CFG_DIAG_IM, '0);
		write_reg(CFG_BAR_H, '0);
		write_reg(CFG_BAR_LO, 32'd0);
		write_reg(CFG_BAR_HI, 32'd1023);
		step_and_probe();
		drain();

		// Random mix of writes, reads and unused kinds with one step in the middle.
		write_reg(CFG_DIAG_RE, $urandom);
		write_reg(CFG_DIAG_IM, $urandom);
		write_reg(CFG_RHS_RE, $urandom);
		write_reg(CFG_RHS_IM, $urandom);
		write_reg(CFG_BAR_H, S32_MAX);
		write_reg(CFG_BAR_LO, $urandom);
		write_reg(CFG_BAR_HI, $urandom);
		for (int n = 0; n < 140; n++) begin
			if (n == 70) begin
				push_op(KIND_STEP, $urandom, $urandom, $urandom);
			end else begin
				r = $urandom_range(99);
				if (r < 48)
					push_op(KIND_WRITE, $urandom_range(NPTS - 1), $urandom, $urandom);
				else if (r < 95)
					push_op(KIND_READ, $urandom_range(NPTS - 1), $urandom, $urandom);
				else
					push_op(KIND_UNUSED, $urandom_range(NPTS - 1), $urandom, $urandom);
			end
			if (n == 100) burst = 1'b1;
		end
		drain();
		burst = 1'b0;

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
